// File: rtl/pfar_pkg.sv
// ----------------------------------------------------------------------------
// pfar_pkg
// Shared types and codes of the page frame allocator with reference counts.
// ----------------------------------------------------------------------------
`default_nettype none

package pfar_pkg;

   // Request kinds.
   localparam logic [2:0] KIND_ALLOC     = 3'd0;
   localparam logic [2:0] KIND_FREE      = 3'd1;
   localparam logic [2:0] KIND_INIT_FREE = 3'd2;
   localparam logic [2:0] KIND_INC       = 3'd3;
   localparam logic [2:0] KIND_DEC       = 3'd4;
   localparam logic [2:0] KIND_QUERY     = 3'd5;

   // Result status codes.
   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_EMPTY   = 2'd1;
   localparam logic [1:0] STAT_BADADDR = 2'd2;
   localparam logic [1:0] STAT_NOTONE  = 2'd3;

   localparam logic [7:0] REF_MAX = 8'hFF;
   localparam logic [7:0] REF_ONE = 8'd1;

   // Configuration port.
   localparam int         CSR_ADDR_W      = 3;
   localparam int         LOWEST_W        = 25;
   localparam logic [2:0] CSR_ADDR_LOWEST = 3'd0;

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_EXEC
   } ctrl_state_type;

   typedef struct packed {
      logic capture;
      logic exec;
      logic clear;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
   } stat_type;

endpackage

`default_nettype wire

// File: rtl/pfar_csr.sv
// ----------------------------------------------------------------------------
// pfar_csr
// Configuration register bank with an APB-style access port.
// ----------------------------------------------------------------------------
`default_nettype none

module pfar_csr (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            psel,
   input  wire logic                            penable,
   input  wire logic                            pwrite,
   input  wire logic [pfar_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [31:0]                     pwdata,
   output logic      [31:0]                     prdata,
   output logic                                 pready,
   output logic      [pfar_pkg::LOWEST_W-1:0]   lowest_free_addr
);
   import pfar_pkg::*;

   logic [LOWEST_W-1:0] lowest_ff;
   logic [LOWEST_W-1:0] lowest_in;
   logic                hit;

   assign hit = (paddr == CSR_ADDR_LOWEST);

   always_comb begin
      lowest_in = lowest_ff;
      if (psel && penable && pwrite && hit) begin
         lowest_in = pwdata[LOWEST_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lowest_ff <= '0;
      end else begin
         lowest_ff <= lowest_in;
      end
   end

   assign prdata           = hit ? {{(32-LOWEST_W){1'b0}}, lowest_ff} : 32'd0;
   assign pready           = 1'b1;
   assign lowest_free_addr = lowest_ff;

endmodule

`default_nettype wire

// File: rtl/pfar_ctrl.sv
// ----------------------------------------------------------------------------
// pfar_ctrl
// Controller: clearing sweep after reset, then accept and execute requests.
// ----------------------------------------------------------------------------
`default_nettype none

module pfar_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire pfar_pkg::stat_type stat,
   output pfar_pkg::cmd_type       cmd,
   output logic                    busy
);
   import pfar_pkg::*;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      busy        = 1'b1;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (stat.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

endmodule

`default_nettype wire

// File: rtl/pfar_datapath.sv
// ----------------------------------------------------------------------------
// pfar_datapath
// Free-list head, link and count memories, address checks and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pfar_datapath #(
   parameter int PAGE_COUNT = 4096,
   parameter int PAGE_SHIFT = 12
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire pfar_pkg::cmd_type             cmd,
   output pfar_pkg::stat_type                 stat,
   input  wire logic [2:0]                    req_kind,
   input  wire logic [31:0]                   req_phys_addr,
   input  wire logic [pfar_pkg::LOWEST_W-1:0] lowest_free_addr,
   output logic                               rsp_valid,
   output logic      [1:0]                    rsp_status,
   output logic      [23:0]                   rsp_page_addr,
   output logic      [7:0]                    rsp_ref_value
);
   import pfar_pkg::*;

   localparam int IDX_W  = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
   localparam int HEAD_W = $clog2(PAGE_COUNT + 1);
   localparam logic [HEAD_W-1:0] END_MARK  = HEAD_W'(PAGE_COUNT);
   localparam logic [IDX_W-1:0]  LAST_PAGE = IDX_W'(PAGE_COUNT - 1);

   logic [7:0]        refs_mem [PAGE_COUNT];
   logic [HEAD_W-1:0] link_mem [PAGE_COUNT];

   logic [2:0]        kind_ff;
   logic [31:0]       addr_ff;
   logic [HEAD_W-1:0] head_ff;
   logic [HEAD_W-1:0] head_in;
   logic [IDX_W-1:0]  clr_cnt_ff;
   logic [7:0]        rd_ref_ff;
   logic [HEAD_W-1:0] rd_next_ff;
   logic              rsp_valid_ff;
   logic [1:0]        status_ff;
   logic [1:0]        status_in;
   logic [23:0]       page_addr_ff;
   logic [23:0]       page_addr_in;
   logic [7:0]        ref_value_ff;
   logic [7:0]        ref_value_in;

   logic [31:0]       req_pg_full;
   logic [IDX_W-1:0]  req_idx;
   logic [31:0]       pg_full;
   logic [IDX_W-1:0]  pg;
   logic [IDX_W-1:0]  head_idx;
   logic [IDX_W+PAGE_SHIFT-1:0] alloc_addr;
   logic              bad_addr;
   logic              head_empty;

   logic              refs_we;
   logic [IDX_W-1:0]  refs_waddr;
   logic [7:0]        refs_wdata;
   logic              link_we;

   assign req_pg_full = req_phys_addr >> PAGE_SHIFT;
   assign req_idx     = req_pg_full[IDX_W-1:0];
   assign pg_full     = addr_ff >> PAGE_SHIFT;
   assign pg          = pg_full[IDX_W-1:0];
   assign head_idx    = head_ff[IDX_W-1:0];
   assign alloc_addr  = {head_idx, {PAGE_SHIFT{1'b0}}};
   assign head_empty  = (head_ff == END_MARK);

   assign bad_addr = (addr_ff[PAGE_SHIFT-1:0] != '0)
                  || (addr_ff < {{(32-LOWEST_W){1'b0}}, lowest_free_addr})
                  || (pg_full >= 32'(PAGE_COUNT));

   always_comb begin
      head_in      = head_ff;
      status_in    = STAT_OK;
      page_addr_in = 24'd0;
      ref_value_in = 8'd0;
      refs_we      = 1'b0;
      refs_waddr   = pg;
      refs_wdata   = 8'd0;
      link_we      = 1'b0;
      case (kind_ff) inside
         KIND_ALLOC: begin
            if (head_empty) begin
               status_in = STAT_EMPTY;
            end else begin
               head_in      = rd_next_ff;
               refs_we      = 1'b1;
               refs_waddr   = head_idx;
               refs_wdata   = REF_ONE;
               page_addr_in = 24'(alloc_addr);
               ref_value_in = REF_ONE;
            end
         end
         KIND_FREE, KIND_INIT_FREE, KIND_INC, KIND_DEC, KIND_QUERY: begin
            if (bad_addr) begin
               status_in = STAT_BADADDR;
            end else if (kind_ff == KIND_FREE && rd_ref_ff != REF_ONE) begin
               status_in    = STAT_NOTONE;
               ref_value_in = rd_ref_ff;
            end else if (kind_ff == KIND_FREE || kind_ff == KIND_INIT_FREE) begin
               // Push: the page links to the old head and becomes the head.
               link_we = 1'b1;
               head_in = HEAD_W'(pg);
               refs_we = 1'b1;
            end else if (kind_ff == KIND_INC) begin
               refs_we      = 1'b1;
               refs_wdata   = (rd_ref_ff == REF_MAX) ? rd_ref_ff : rd_ref_ff + 8'd1;
               ref_value_in = refs_wdata;
            end else if (kind_ff == KIND_DEC) begin
               refs_we      = 1'b1;
               refs_wdata   = (rd_ref_ff == 8'd0) ? rd_ref_ff : rd_ref_ff - 8'd1;
               ref_value_in = refs_wdata;
            end else begin
               ref_value_in = rd_ref_ff;
            end
         end
         default: begin
         end
      endcase

      if (!cmd.exec) begin
         refs_we = 1'b0;
         link_we = 1'b0;
         head_in = head_ff;
      end
      // The clearing sweep after reset owns the count memory port.
      if (cmd.clear) begin
         refs_we    = 1'b1;
         refs_waddr = clr_cnt_ff;
         refs_wdata = 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (refs_we) begin
         refs_mem[refs_waddr] <= refs_wdata;
      end
      if (link_we) begin
         link_mem[pg] <= head_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         rd_ref_ff  <= refs_mem[req_idx];
         rd_next_ff <= link_mem[head_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff <= req_kind;
         addr_ff <= req_phys_addr;
      end
      if (cmd.exec) begin
         status_ff    <= status_in;
         page_addr_ff <= page_addr_in;
         ref_value_ff <= ref_value_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= END_MARK;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         rsp_valid_ff <= cmd.exec;
         if (cmd.clear) begin
            clr_cnt_ff <= clr_cnt_ff + 1'b1;
         end
      end
   end

   assign stat.clear_last = (clr_cnt_ff == LAST_PAGE);

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = status_ff;
   assign rsp_page_addr = page_addr_ff;
   assign rsp_ref_value = ref_value_ff;

endmodule

`default_nettype wire

// File: rtl/page_frame_allocator_refcount_top.sv
// ----------------------------------------------------------------------------
// page_frame_allocator_refcount_top
// Page frame allocator: LIFO free list with a saturating count for each page.
// ----------------------------------------------------------------------------
// A request item (req_kind, req_phys_addr) is taken at a clock edge where
// start is high and busy is low. The item is read from the link and count
// memories at that edge, executed in the following cycle, and its result is
// shown on the rsp_ ports with rsp_valid high for exactly one cycle right
// after that. Busy is high during the execute cycle, set by the read and then
// read-modify-write of the single-port memories. A new item may be accepted
// in the same cycle that the previous result is shown.
// The receiver cannot stall; each result is taken in its cycle.
// After reset the block sweeps the count memory to zero, one page a cycle,
// with busy high until the last page is cleared; the free list starts empty.
// lowest_free_addr is written through the APB-style port at address 0 by the
// user only while idle (the block does not enforce it); pready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module page_frame_allocator_refcount_top #(
   parameter int PAGE_COUNT = 4096,
   parameter int PAGE_SHIFT = 12
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   output logic                                 busy,
   input  wire logic [2:0]                      req_kind,
   input  wire logic [31:0]                     req_phys_addr,
   output logic                                 rsp_valid,
   output logic      [1:0]                      rsp_status,
   output logic      [23:0]                     rsp_page_addr,
   output logic      [7:0]                      rsp_ref_value,
   input  wire logic                            psel,
   input  wire logic                            penable,
   input  wire logic                            pwrite,
   input  wire logic [pfar_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [31:0]                     pwdata,
   output logic      [31:0]                     prdata,
   output logic                                 pready
);
   import pfar_pkg::*;

   cmd_type             cmd;
   stat_type            stat;
   logic [LOWEST_W-1:0] lowest_free_addr;

   pfar_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready),
      .lowest_free_addr (lowest_free_addr)
   );

   pfar_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .cmd   (cmd),
      .busy  (busy)
   );

   pfar_datapath #(
      .PAGE_COUNT (PAGE_COUNT),
      .PAGE_SHIFT (PAGE_SHIFT)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_kind         (req_kind),
      .req_phys_addr    (req_phys_addr),
      .lowest_free_addr (lowest_free_addr),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_page_addr    (rsp_page_addr),
      .rsp_ref_value    (rsp_ref_value)
   );

   // An accepted item is executed in the very next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> cmd.exec)
      else $error("accepted item was not executed");

   // A result only follows an execute cycle.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(cmd.exec))
      else $error("result without an execute cycle");

   // A bad address leaves page address and count at zero.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STAT_BADADDR) |->
         (rsp_page_addr == 24'd0 && rsp_ref_value == 8'd0))
      else $error("bad address result carries data");

   // A nonzero page address only comes from a successful allocate.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_page_addr != 24'd0) |->
         (rsp_status == STAT_OK && rsp_ref_value == REF_ONE))
      else $error("allocated page without a count of one");

endmodule

`default_nettype wire
